// ----- hw/rtl/mcq_pkg.sv -----
// mcq_pkg: shared types and constants for the multi-class token queue dispatcher.
// Holds the request/result word structs, status codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package mcq_pkg;

    localparam int NUM_Q      = 4;
    localparam int QSEL_W     = 2;
    localparam int CLASS_LIM_W = 6;
    localparam int TOTAL_LIM_W = 10;
    localparam int TOK_W      = 10;
    localparam int STATUS_W   = 3;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CLASS_LIM_W-1:0] CLASS_LIMIT_RST = 6'd25;
    localparam logic [TOTAL_LIM_W-1:0] TOTAL_LIMIT_RST = 10'd100;

    localparam logic [CFG_IDX_W-1:0] REG_CLASS_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LIMIT = 1'b1;

    localparam logic FUNC_ISSUE = 1'b0;
    localparam logic FUNC_SERVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ISSUED      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOTAL_LIMIT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLASS_LIMIT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SERVED      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE        = 3'd4;

    typedef struct packed {
        logic              func;
        logic [QSEL_W-1:0] visa_class;
        logic [QSEL_W-1:0] counter_index;
    } in_word_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TOK_W-1:0]    token_number;
        logic [QSEL_W-1:0]   token_class;
    } out_word_t;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_TOT   = 8'b0000_0010,
        S_CLS   = 8'b0000_0100,
        S_DEP   = 8'b0000_1000,
        S_OWN   = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_FETCH = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } seq_state_t;

endpackage

// ----- hw/rtl/mcq_store.sv -----
// mcq_store: token storage for all class rings, one write and one read port.
// Address is {class, slot}; read data is registered.
// Depends on nothing.
`timescale 1ns / 1ps

module mcq_store #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 10
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mcq_seq.sv -----
// mcq_seq: request sequencer with one shared >= comparator, ring pointers,
// queue counts and the issued counter. Instantiates mcq_store.
// Depends on mcq_pkg.
`timescale 1ns / 1ps

module mcq_seq #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TOKEN_WIDTH = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  mcq_pkg::in_word_t               req,
    output logic                            idle,
    input  logic [mcq_pkg::CLASS_LIM_W-1:0] class_limit,
    input  logic [mcq_pkg::TOTAL_LIM_W-1:0] total_limit,
    output logic                            done_valid,
    input  logic                            done_ack,
    output mcq_pkg::out_word_t              result
);
    import mcq_pkg::*;

    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CW    = (CNT_W > TOTAL_LIM_W) ? CNT_W : TOTAL_LIM_W;
    localparam int AW    = QSEL_W + PW;
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [QSEL_W-1:0] Q_LAST = QSEL_W'(NUM_Q - 1);

    seq_state_t state_reg, state_next;

    logic [QSEL_W-1:0] cls_reg, srv_reg, idx_reg, pick_reg;
    logic [QSEL_W-1:0] cls_next, srv_next, idx_next, pick_next;
    logic [CNT_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;

    logic [PW-1:0]     head_reg [NUM_Q];
    logic [PW-1:0]     head_next [NUM_Q];
    logic [PW-1:0]     tail_reg [NUM_Q];
    logic [PW-1:0]     tail_next [NUM_Q];
    logic [CNT_W-1:0]  cnt_reg [NUM_Q];
    logic [CNT_W-1:0]  cnt_next [NUM_Q];
    logic [TOTAL_LIM_W-1:0] issued_reg, issued_next;

    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [TOK_W-1:0]    res_token_reg, res_token_next;
    logic [QSEL_W-1:0]   res_class_reg, res_class_next;
    logic                use_mem_reg, use_mem_next;

    // shared compare unit
    logic [CW-1:0] cmp_a, cmp_b;
    logic          cmp_ge;

    logic [QSEL_W-1:0] q_sel;
    logic [CNT_W-1:0]  q_cnt;
    logic [PW-1:0]     q_head, q_tail;

    logic [TOK_W-1:0]             tok_full;
    logic [TOK_W+TOKEN_WIDTH-1:0] tok_ext;
    logic [TOKEN_WIDTH-1:0]       tok_store;
    logic [TOK_W+TOKEN_WIDTH-1:0] tok_back_ext;
    logic [TOK_W+TOKEN_WIDTH-1:0] rd_back_ext;

    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [TOKEN_WIDTH-1:0] mem_rdata;
    logic                   scan_hit;

    always_comb
    begin
        case (state_reg)
            S_CLS, S_DEP: q_sel = cls_reg;
            S_OWN:        q_sel = srv_reg;
            S_SCAN:       q_sel = idx_reg;
            S_FETCH:      q_sel = pick_reg;
            default:      q_sel = cls_reg;
        endcase
    end

    assign q_cnt  = cnt_reg[q_sel];
    assign q_head = head_reg[q_sel];
    assign q_tail = tail_reg[q_sel];

    always_comb
    begin
        case (state_reg)
            S_TOT:
            begin
                cmp_a = CW'(issued_reg);
                cmp_b = CW'(total_limit);
            end
            S_CLS:
            begin
                cmp_a = CW'(q_cnt);
                cmp_b = CW'(class_limit);
            end
            S_DEP:
            begin
                cmp_a = CW'(q_cnt);
                cmp_b = CW'(QUEUE_DEPTH);
            end
            S_OWN:
            begin
                cmp_a = CW'(q_cnt);
                cmp_b = CW'(1);
            end
            S_SCAN:
            begin
                cmp_a = CW'(best_reg);
                cmp_b = CW'(q_cnt);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_ge = (cmp_a >= cmp_b);

    // token = issued + 1, masked to the stored width and widened back for the port
    assign tok_full     = issued_reg + TOK_W'(1);
    assign tok_ext      = {{TOKEN_WIDTH{1'b0}}, tok_full};
    assign tok_store    = tok_ext[TOKEN_WIDTH-1:0];
    assign tok_back_ext = {{TOK_W{1'b0}}, tok_store};
    assign rd_back_ext  = {{TOK_W{1'b0}}, mem_rdata};

    // strictly longer than the best so far, own queue skipped
    assign scan_hit = (idx_reg != srv_reg) && !cmp_ge;

    always_comb
    begin
        state_next      = state_reg;
        cls_next        = cls_reg;
        srv_next        = srv_reg;
        idx_next        = idx_reg;
        pick_next       = pick_reg;
        best_next       = best_reg;
        found_next      = found_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cnt_next        = cnt_reg;
        issued_next     = issued_reg;
        res_status_next = res_status_reg;
        res_token_next  = res_token_reg;
        res_class_next  = res_class_reg;
        use_mem_next    = use_mem_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = {cls_reg, q_tail};
        mem_raddr       = {pick_reg, q_head};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cls_next   = req.visa_class;
                    srv_next   = req.counter_index;
                    state_next = (req.func == FUNC_SERVE) ? S_OWN : S_TOT;
                end
            end
            S_TOT:
            begin
                if (cmp_ge)
                begin
                    res_status_next = ST_TOTAL_LIMIT;
                    res_token_next  = '0;
                    res_class_next  = cls_reg;
                    use_mem_next    = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_CLS;
                end
            end
            S_CLS:
            begin
                if (cmp_ge)
                begin
                    res_status_next = ST_CLASS_LIMIT;
                    res_token_next  = '0;
                    res_class_next  = cls_reg;
                    use_mem_next    = 1'b0;
                    state_next      = S_DONE;
                end
                else
                begin
                    state_next = S_DEP;
                end
            end
            S_DEP:
            begin
                res_class_next = cls_reg;
                use_mem_next   = 1'b0;
                if (cmp_ge)
                begin
                    res_status_next = ST_CLASS_LIMIT;
                    res_token_next  = '0;
                end
                else
                begin
                    mem_we             = 1'b1;
                    tail_next[cls_reg] = (q_tail == PTR_LAST) ? '0 : q_tail + PW'(1);
                    cnt_next[cls_reg]  = q_cnt + CNT_W'(1);
                    issued_next        = tok_full;
                    res_status_next    = ST_ISSUED;
                    res_token_next     = tok_back_ext[TOK_W-1:0];
                end
                state_next = S_DONE;
            end
            S_OWN:
            begin
                if (cmp_ge)
                begin
                    pick_next  = srv_reg;
                    state_next = S_FETCH;
                end
                else
                begin
                    idx_next   = '0;
                    best_next  = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_hit)
                begin
                    best_next  = q_cnt;
                    pick_next  = idx_reg;
                    found_next = 1'b1;
                end
                idx_next = idx_reg + QSEL_W'(1);
                if (idx_reg == Q_LAST)
                begin
                    if (found_reg || scan_hit)
                    begin
                        state_next = S_FETCH;
                    end
                    else
                    begin
                        res_status_next = ST_NONE;
                        res_token_next  = '0;
                        res_class_next  = '0;
                        use_mem_next    = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_FETCH:
            begin
                mem_re              = 1'b1;
                head_next[pick_reg] = (q_head == PTR_LAST) ? '0 : q_head + PW'(1);
                cnt_next[pick_reg]  = q_cnt - CNT_W'(1);
                res_status_next     = ST_SERVED;
                res_class_next      = pick_reg;
                use_mem_next        = 1'b1;
                state_next          = S_DONE;
            end
            S_DONE:
            begin
                if (done_ack)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            issued_reg <= '0;
            for (int i = 0; i < NUM_Q; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg        <= cls_next;
        srv_reg        <= srv_next;
        idx_reg        <= idx_next;
        pick_reg       <= pick_next;
        best_reg       <= best_next;
        found_reg      <= found_next;
        res_status_reg <= res_status_next;
        res_token_reg  <= res_token_next;
        res_class_reg  <= res_class_next;
        use_mem_reg    <= use_mem_next;
    end

    mcq_store #(
        .ADDR_W (AW),
        .DATA_W (TOKEN_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (tok_store),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign idle       = (state_reg == S_IDLE);
    assign done_valid = (state_reg == S_DONE);

    always_comb
    begin
        result.status       = res_status_reg;
        result.token_number = use_mem_reg ? rd_back_ext[TOK_W-1:0] : res_token_reg;
        result.token_class  = res_class_reg;
    end

endmodule

// ----- hw/rtl/multi_class_token_queue_dispatcher.sv -----
// Multi-class token queue dispatcher: issues sequential token numbers into four
// class rings and serves them back, own queue first, else the longest other queue
// (lowest index on ties). One request is handled at a time by a sequencer that
// steps a single shared comparator: an issue request runs the total-limit, class-limit
// and ring-depth checks and then writes the token (stopping early when refused at
// the total-limit or class-limit check); a serve from the server's own queue goes
// straight to the registered ring-store read, and a serve that has to search the
// other queues compares one queue per cycle, then does the registered ring-store
// read, or ends with no token when every other queue is empty. A finished result
// sits in an output register, so the next request is accepted while the previous
// word waits to be taken. The token store needs no clearing after reset. The user
// writes limits through cfg_we / cfg_index / cfg_data while no request is in flight;
// the block itself does not enforce this. Depends on mcq_pkg, mcq_seq, mcq_store.
`timescale 1ns / 1ps

module multi_class_token_queue_dispatcher #(
    parameter int QUEUE_DEPTH = 32,
    parameter int TOKEN_WIDTH = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mcq_pkg::in_word_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mcq_pkg::out_word_t             out_data,
    input  logic                           cfg_we,
    input  logic [mcq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mcq_pkg::*;

    logic [CLASS_LIM_W-1:0] class_limit_reg;
    logic [TOTAL_LIM_W-1:0] total_limit_reg;

    logic      out_valid_reg, out_valid_next;
    out_word_t out_data_reg, out_data_next;

    logic      seq_idle;
    logic      seq_done;
    logic      seq_ack;
    out_word_t seq_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_limit_reg <= CLASS_LIMIT_RST;
            total_limit_reg <= TOTAL_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLASS_LIMIT: class_limit_reg <= cfg_data[CLASS_LIM_W-1:0];
                REG_TOTAL_LIMIT: total_limit_reg <= cfg_data[TOTAL_LIM_W-1:0];
                default:         ;
            endcase
        end
    end

    assign in_ready = seq_idle;

    mcq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TOKEN_WIDTH (TOKEN_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_valid),
        .req         (in_data),
        .idle        (seq_idle),
        .class_limit (class_limit_reg),
        .total_limit (total_limit_reg),
        .done_valid  (seq_done),
        .done_ack    (seq_ack),
        .result      (seq_result)
    );

    // output word register: load when empty or being drained
    assign seq_ack = seq_done && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (seq_ack)
        begin
            out_valid_next = 1'b1;
            out_data_next  = seq_result;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
